FILE: src/bgca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgca_pkg
// types and fixed-point constants shared by the barometric altitude block
// ----------------------------------------------------------------------------
package bgca_pkg;

    // field and datapath widths
    localparam int PRESS_W   = 21;
    localparam int SETTLE_W  = 16;
    localparam int OUT_W     = 22;
    localparam int EST_W     = 32;
    localparam int Q12_SHIFT = 12;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // altitude law intermediates
    localparam int MAG_W    = 31;
    localparam int X_W      = 32;
    localparam int T16_W    = 25;
    localparam int T2_W     = 33;
    localparam int T3_W     = 41;
    localparam int Y_W      = 47;
    localparam int Z_W      = 45;
    localparam int ZH_W     = 22;
    localparam int ZL_W     = 23;
    localparam int DV_W     = 28;
    localparam int DQ_W     = 24;
    localparam int DR_W     = 5;
    localparam int QH_W     = 18;
    localparam int CUB_W    = QH_W + ZL_W;
    localparam int SUM_W    = 42;
    localparam int ARAW_W   = 26;
    localparam int A_W      = 24;
    localparam int ALT_W    = 25;
    localparam int DIFF_W   = 26;
    localparam int GP_W     = 48;
    localparam int T2P_W    = 50;
    localparam int T3P_W    = 58;
    localparam int RND_SHIFT = 16;

    // constants
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd500;
    localparam logic [EST_W-1:0]    EST_RESET    = 32'd415027200;  // 101325 Pa, Q.12
    localparam logic [EST_W-1:0]    REF_Q12      = 32'd413696000;  // 101000 Pa, Q.12
    localparam logic [EST_W-1:0]    MAG_LIMIT    = 32'd1073741824; // 2^18 Pa, Q.12
    localparam logic [15:0]         GAIN_Q16     = 16'd9830;
    localparam logic [15:0]         TOL_DIV      = 16'd20000;
    localparam logic [31:0]         M125         = 32'd2199023255; // floor(2^38/125)
    localparam int                  M125_SHIFT   = 38;
    localparam logic [31:0]         M25          = 32'd171798691;  // floor(2^32/25)
    localparam int                  M25_SHIFT    = 32;
    localparam logic [A_W-1:0]      ALT_LIMIT    = 24'd8388608;    // 2^23 cm
    localparam logic [15:0]         RND_HALF     = 16'd32768;
    localparam logic [7:0]          X_BIAS       = 8'd62;
    localparam logic [7:0]          DIV_125      = 8'd125;
    localparam logic [7:0]          DIV_25       = 8'd25;
    localparam logic [7:0]          CUB_BIAS     = 8'd25;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CALIB  = 1'b1;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_op;

    typedef struct packed {
        logic signed [OUT_W-1:0] altitude_cm;
        logic                    calibrated;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_E_GAIN,
        ST_E_TOL,
        ST_E_TEST,
        ST_A_MAG,
        ST_A_DIV,
        ST_A_Q,
        ST_A_QFIX,
        ST_A_SQ,
        ST_A_T2,
        ST_A_CUBE,
        ST_A_T3,
        ST_A_Z,
        ST_A_HDIV,
        ST_A_HQ,
        ST_A_HFIX,
        ST_A_LDIV,
        ST_A_LQ,
        ST_A_LFIX,
        ST_A_SUM,
        ST_A_OUT,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

FILE: src/baro_ground_calibration_altitude_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_ground_calibration_altitude_top
// barometric altitude relative to a calibrated ground pressure
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) carries one word: a pressure sample
// (i_req_type 0) or a start-calibration request (i_req_type 1) with its tick.
// output channel (o_out_valid / i_out_ready) returns one word per input word:
// altitude in cm above ground and the calibrated flag.
// settle_ticks is written through i_cfg_we / i_cfg_wdata; the user writes it
// only while idle, as the block itself does not enforce this.
// words are processed one at a time by a sequencer around one shared
// multiplier; o_in_ready rises on the edge that moves the result into the
// output register, together with o_out_valid.
// a result waiting on a stalled receiver does not block the next word, but a
// second result waits in the sequencer until the output register frees up.
// reset: estimate 101325 Pa, uncalibrated, settle_ticks 500, output empty.
// ----------------------------------------------------------------------------
module baro_ground_calibration_altitude_top #(
    parameter int TICK_BITS          = 32,
    parameter int PRESSURE_FRAC_BITS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [bgca_pkg::PRESS_W-1:0]  i_pressure,
    input  wire logic [TICK_BITS-1:0]          i_tick_now,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [bgca_pkg::OUT_W-1:0]  o_altitude_cm,
    output logic                               o_calibrated,
    // settle_ticks register
    input  wire logic                          i_cfg_we,
    input  wire logic [bgca_pkg::SETTLE_W-1:0] i_cfg_wdata
);
    import bgca_pkg::*;

    logic [SETTLE_W-1:0] r_settle;
    logic                r_out_valid;
    t_result             r_out_res;

    logic    w_idle;
    logic    w_done;
    logic    w_res_ready;
    logic    w_start;
    t_result w_res;

    // output register free, or being emptied this cycle
    assign w_res_ready = !r_out_valid || i_out_ready;
    assign w_start     = i_in_valid && w_idle;

    bgca_core #(
        .TICK_BITS          (TICK_BITS),
        .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_req_type  (i_req_type),
        .i_pressure  (i_pressure),
        .i_tick      (i_tick_now),
        .i_settle    (r_settle),
        .i_res_ready (w_res_ready),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    // control: config register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= SETTLE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_settle <= i_cfg_wdata;
            end
            if (w_done && w_res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_done && w_res_ready) begin
            r_out_res <= w_res;
        end
    end

    assign o_in_ready    = w_idle;
    assign o_out_valid   = r_out_valid;
    assign o_altitude_cm = r_out_res.altitude_cm;
    assign o_calibrated  = r_out_res.calibrated;

endmodule
`default_nettype wire

FILE: src/bgca_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgca_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module bgca_mul (
    input  wire logic                     i_clk,
    input  wire bgca_pkg::t_mul_op        i_op,
    output logic [bgca_pkg::MUL_P_W-1:0]  o_prod
);
    import bgca_pkg::*;

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_op.a) * MUL_P_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

FILE: src/bgca_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgca_core
// sequencer, calibration state and altitude datapath around one multiplier
// ----------------------------------------------------------------------------
module bgca_core #(
    parameter int TICK_BITS          = 32,
    parameter int PRESSURE_FRAC_BITS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_req_type,
    input  wire logic [bgca_pkg::PRESS_W-1:0]  i_pressure,
    input  wire logic [TICK_BITS-1:0]          i_tick,
    input  wire logic [bgca_pkg::SETTLE_W-1:0] i_settle,
    input  wire logic                          i_res_ready,
    output logic                               o_idle,
    output logic                               o_done,
    output bgca_pkg::t_result                  o_res
);
    import bgca_pkg::*;

    localparam int P_SHIFT = Q12_SHIFT - PRESSURE_FRAC_BITS;
    localparam int P12_W   = PRESS_W + P_SHIFT;
    localparam int PV_W    = (P12_W > EST_W) ? P12_W : EST_W;

    typedef struct packed {
        logic [DQ_W-1:0] q;
        logic [DR_W-1:0] r;
    } t_divq;

    // fix up a reciprocal quotient estimate that may be one low
    function automatic t_divq div25_fix(input logic [DV_W-1:0] x, input logic [DQ_W-1:0] q);
        logic [DV_W-1:0] m;
        logic [DV_W-1:0] rem;
        t_divq res;
        m   = (DV_W'(q) << 4) + (DV_W'(q) << 3) + DV_W'(q);
        rem = x - m;
        if (rem >= DV_W'(DIV_25)) begin
            res.q = q + DQ_W'(1);
            res.r = DR_W'(rem - DV_W'(DIV_25));
        end else begin
            res.q = q;
            res.r = DR_W'(rem);
        end
        return res;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}));
        lo = DIFF_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}));
        if (v > hi) begin
            return hi[OUT_W-1:0];
        end else if (v < lo) begin
            return lo[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    // state registers and next values
    t_state r_state, n_state;
    logic [EST_W-1:0]     r_est, n_est;
    logic [TICK_BITS-1:0] r_stable, n_stable;
    logic signed [OUT_W-1:0] r_ground, n_ground;
    logic                 r_calib, n_calib;

    // per-word working registers
    logic                 r_req, n_req;
    logic [PV_W-1:0]      r_pval, n_pval;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic                 r_up, n_up;
    logic [PV_W-1:0]      r_emag, n_emag;
    logic                 r_cal_path, n_cal_path;
    logic                 r_neg, n_neg;
    logic [MAG_W-1:0]     r_mag, n_mag;
    logic [T16_W-1:0]     r_t16, n_t16;
    logic [T2_W-1:0]      r_t2, n_t2;
    logic [T3_W-1:0]      r_t3, n_t3;
    logic [Z_W-1:0]       r_z, n_z;
    logic [DV_W-1:0]      r_dx, n_dx;
    logic [DQ_W-1:0]      r_dq, n_dq;
    logic [DR_W-1:0]      r_dr, n_dr;
    logic [QH_W-1:0]      r_qh, n_qh;
    logic [ZL_W-1:0]      r_ql, n_ql;
    logic signed [ALT_W-1:0] r_alt, n_alt;
    t_result              r_res, n_res;

    t_mul_op              w_mul_op;
    logic [MUL_P_W-1:0]   w_prod;

    bgca_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_mul_op),
        .o_prod (w_prod)
    );

    // estimate update
    logic [GP_W-1:0]      w_dsum;
    logic [EST_W-1:0]     w_delta;
    logic [EST_W:0]       w_est_up;
    logic                 w_tol;
    logic [TICK_BITS-1:0] w_elapsed;
    logic                 w_settled;

    assign w_dsum    = w_prod[GP_W-1:0] + GP_W'(RND_HALF);
    assign w_delta   = w_dsum[RND_SHIFT +: EST_W];
    assign w_est_up  = {1'b0, r_est} + {1'b0, w_delta};
    assign w_tol     = w_prod < MUL_P_W'(r_est);
    assign w_elapsed = r_tick - r_stable;
    assign w_settled = w_elapsed > TICK_BITS'(i_settle);

    // altitude law
    logic [PV_W-1:0]   w_below, w_above;
    logic [X_W-1:0]    w_x;
    logic [X_W:0]      w_m125, w_rem125;
    logic [T2P_W-1:0]  w_t2_sum;
    logic [T3P_W-1:0]  w_t3_sum;
    logic [Y_W-1:0]    w_y;
    logic [DV_W-1:0]   w_wlo;
    t_divq             w_fix;
    logic [CUB_W-1:0]  w_cub;
    logic [SUM_W-1:0]  w_lin, w_sum;
    logic [ARAW_W-1:0] w_araw;
    logic [A_W-1:0]    w_aclamp;
    logic signed [DIFF_W-1:0] w_diff;

    assign w_below  = PV_W'(REF_Q12) - r_pval;
    assign w_above  = r_pval - PV_W'(REF_Q12);
    assign w_x      = {r_mag, 1'b0} + X_W'(X_BIAS);
    assign w_m125   = ((X_W+1)'(r_t16) << 7) - ((X_W+1)'(r_t16) << 2) + (X_W+1)'(r_t16);
    assign w_rem125 = (X_W+1)'(w_x) - w_m125;
    assign w_t2_sum = w_prod[T2P_W-1:0] + T2P_W'(RND_HALF);
    assign w_t3_sum = w_prod[T3P_W-1:0] + T3P_W'(RND_HALF);
    assign w_y      = (Y_W'(r_t3) << 5) + (Y_W'(r_t3) << 3) + Y_W'(r_t3) + Y_W'(CUB_BIAS);
    assign w_wlo    = {r_dr, r_z[ZL_W-1:0]};
    assign w_fix    = div25_fix(r_dx, r_dq);
    assign w_cub    = {r_qh, r_ql};
    assign w_lin    = (SUM_W'(r_mag) << 7) + (SUM_W'(r_mag) << 4);
    assign w_sum    = SUM_W'(w_cub) + w_lin + SUM_W'(RND_HALF);
    assign w_araw   = w_sum[RND_SHIFT +: ARAW_W];
    assign w_aclamp = (w_araw > ARAW_W'(ALT_LIMIT)) ? ALT_LIMIT : w_araw[A_W-1:0];
    assign w_diff   = DIFF_W'(r_alt) - DIFF_W'(r_ground);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_est    <= EST_RESET;
            r_stable <= '0;
            r_ground <= '0;
            r_calib  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_est    <= n_est;
            r_stable <= n_stable;
            r_ground <= n_ground;
            r_calib  <= n_calib;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pval     <= n_pval;
        r_tick     <= n_tick;
        r_up       <= n_up;
        r_emag     <= n_emag;
        r_cal_path <= n_cal_path;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_t16      <= n_t16;
        r_t2       <= n_t2;
        r_t3       <= n_t3;
        r_z        <= n_z;
        r_dx       <= n_dx;
        r_dq       <= n_dq;
        r_dr       <= n_dr;
        r_qh       <= n_qh;
        r_ql       <= n_ql;
        r_alt      <= n_alt;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_est      = r_est;
        n_stable   = r_stable;
        n_ground   = r_ground;
        n_calib    = r_calib;
        n_req      = r_req;
        n_pval     = r_pval;
        n_tick     = r_tick;
        n_up       = r_up;
        n_emag     = r_emag;
        n_cal_path = r_cal_path;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_t16      = r_t16;
        n_t2       = r_t2;
        n_t3       = r_t3;
        n_z        = r_z;
        n_dx       = r_dx;
        n_dq       = r_dq;
        n_dr       = r_dr;
        n_qh       = r_qh;
        n_ql       = r_ql;
        n_alt      = r_alt;
        n_res      = r_res;
        w_mul_op   = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req   = i_req_type;
                    n_pval  = PV_W'(i_pressure) << P_SHIFT;
                    n_tick  = i_tick;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_req == REQ_CALIB) begin
                    n_stable = r_tick;
                    n_calib  = 1'b0;
                    n_res.altitude_cm = '0;
                    n_res.calibrated  = 1'b0;
                    n_state  = ST_FIN;
                end else if (!r_calib) begin
                    if (r_pval >= PV_W'(r_est)) begin
                        n_up   = 1'b1;
                        n_emag = r_pval - PV_W'(r_est);
                    end else begin
                        n_up   = 1'b0;
                        n_emag = PV_W'(r_est) - r_pval;
                    end
                    n_state = ST_E_GAIN;
                end else begin
                    n_cal_path = 1'b0;
                    n_state    = ST_A_MAG;
                end
            end
            // error times gain
            ST_E_GAIN: begin
                w_mul_op.a = MUL_A_W'(r_emag);
                w_mul_op.b = MUL_B_W'(GAIN_Q16);
                n_state    = ST_E_TOL;
            end
            ST_E_TOL: begin
                if (r_up) begin
                    n_est = w_est_up[EST_W] ? '1 : w_est_up[EST_W-1:0];
                end else begin
                    n_est = r_est - w_delta;
                end
                w_mul_op.a = MUL_A_W'(r_emag);
                w_mul_op.b = MUL_B_W'(TOL_DIV);
                n_state    = ST_E_TEST;
            end
            ST_E_TEST: begin
                n_res.altitude_cm = '0;
                n_res.calibrated  = 1'b0;
                if (w_tol) begin
                    if (w_settled) begin
                        n_pval     = PV_W'(r_est);
                        n_cal_path = 1'b1;
                        n_state    = ST_A_MAG;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else begin
                    n_stable = r_tick;
                    n_state  = ST_FIN;
                end
            end
            ST_A_MAG: begin
                if (r_pval <= PV_W'(REF_Q12)) begin
                    n_neg = 1'b0;
                    n_mag = (w_below > PV_W'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : MAG_W'(w_below);
                end else begin
                    n_neg = 1'b1;
                    n_mag = (w_above > PV_W'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : MAG_W'(w_above);
                end
                n_state = ST_A_DIV;
            end
            // t = d / 1000 in Q16, as (2d + 62) / 125
            ST_A_DIV: begin
                w_mul_op.a = MUL_A_W'(w_x);
                w_mul_op.b = M125;
                n_state    = ST_A_Q;
            end
            ST_A_Q: begin
                n_t16   = w_prod[M125_SHIFT +: T16_W];
                n_state = ST_A_QFIX;
            end
            ST_A_QFIX: begin
                if (w_rem125 >= (X_W+1)'(DIV_125)) begin
                    n_t16 = r_t16 + T16_W'(1);
                end
                n_state = ST_A_SQ;
            end
            ST_A_SQ: begin
                w_mul_op.a = MUL_A_W'(r_t16);
                w_mul_op.b = MUL_B_W'(r_t16);
                n_state    = ST_A_T2;
            end
            ST_A_T2: begin
                n_t2    = w_t2_sum[RND_SHIFT +: T2_W];
                n_state = ST_A_CUBE;
            end
            ST_A_CUBE: begin
                w_mul_op.a = MUL_A_W'(r_t2);
                w_mul_op.b = MUL_B_W'(r_t16);
                n_state    = ST_A_T3;
            end
            ST_A_T3: begin
                n_t3    = w_t3_sum[RND_SHIFT +: T3_W];
                n_state = ST_A_Z;
            end
            // (41 t3 + 25) / 50, halved first, then split into two chunks over 25
            ST_A_Z: begin
                n_z     = w_y[1 +: Z_W];
                n_state = ST_A_HDIV;
            end
            ST_A_HDIV: begin
                w_mul_op.a = MUL_A_W'(r_z[Z_W-1 -: ZH_W]);
                w_mul_op.b = M25;
                n_dx       = DV_W'(r_z[Z_W-1 -: ZH_W]);
                n_state    = ST_A_HQ;
            end
            ST_A_HQ: begin
                n_dq    = w_prod[M25_SHIFT +: DQ_W];
                n_state = ST_A_HFIX;
            end
            ST_A_HFIX: begin
                n_qh    = w_fix.q[QH_W-1:0];
                n_dr    = w_fix.r;
                n_state = ST_A_LDIV;
            end
            ST_A_LDIV: begin
                w_mul_op.a = MUL_A_W'(w_wlo);
                w_mul_op.b = M25;
                n_dx       = w_wlo;
                n_state    = ST_A_LQ;
            end
            ST_A_LQ: begin
                n_dq    = w_prod[M25_SHIFT +: DQ_W];
                n_state = ST_A_LFIX;
            end
            ST_A_LFIX: begin
                n_ql    = w_fix.q[ZL_W-1:0];
                n_state = ST_A_SUM;
            end
            ST_A_SUM: begin
                if (r_neg) begin
                    n_alt = -signed'(ALT_W'(w_aclamp));
                end else begin
                    n_alt = signed'(ALT_W'(w_aclamp));
                end
                n_state = ST_A_OUT;
            end
            ST_A_OUT: begin
                if (r_cal_path) begin
                    n_ground          = sat_out(DIFF_W'(r_alt));
                    n_calib           = 1'b1;
                    n_res.altitude_cm = '0;
                    n_res.calibrated  = 1'b1;
                end else begin
                    n_res.altitude_cm = sat_out(w_diff);
                    n_res.calibrated  = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_FIN);
    assign o_res  = r_res;

endmodule
`default_nettype wire

FILE: test/baro_ground_calibration_altitude_top_tb.sv
// ----------------------------------------------------------------------------
// baro_ground_calibration_altitude_top_tb
// self-checking bench for the barometric altitude block with ground calibration
// ----------------------------------------------------------------------------
// a shadow model of the estimator, settle timer and cubic altitude law runs
// alongside the block. every accepted input word produces one expected result
// word, which is compared field by field with what comes out. directed words
// cover the reset register value, tick wrap, settle extremes and pressure
// extremes. random calibration runs follow with noisy samples, stray words and
// settle changes in between. both handshakes idle at random.
// ----------------------------------------------------------------------------
module baro_ground_calibration_altitude_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgca_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 12;
    localparam int     QUIET_CYCLES = 40;          // well past the worst latency
    localparam longint TIMEOUT_NS   = 5_000_000;
    localparam int     RANDOM_WORDS = 880;
    localparam int     IDLE_PCT     = 9;
    localparam int     FRAC_BITS    = 4;
    localparam int     ONE_PA       = 16;          // 1 Pa in the Q.4 input format

    // shadow model constants, Q.12 pressures
    localparam logic [63:0] EST_AT_RESET = 64'd101325 << 12;
    localparam logic [63:0] SEA_REF_Q12  = 64'd101000 << 12;
    localparam logic [63:0] DELTA_CLAMP  = 64'd1 << 30;
    localparam logic [63:0] ALT_CLAMP    = 64'd1 << 23;
    localparam logic [63:0] EST_GAIN     = 64'd9830;   // 0.15 in Q16
    localparam logic [63:0] TOL_RATIO    = 64'd20000;
    localparam logic [63:0] EST_CEIL     = 64'hFFFF_FFFF;
    localparam longint      OUT_HI       = 2097151;
    localparam longint      OUT_LO       = -2097152;

    localparam logic [PRESS_W-1:0] GROUND_Q4 = 21'd1621200;  // 101325 Pa
    localparam logic [PRESS_W-1:0] SEA_Q4    = 21'd1616000;  // 101000 Pa
    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

    // dut connections, all inputs known from time zero
    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic                       req_type    = REQ_SAMPLE;
    logic [PRESS_W-1:0]         pressure    = '0;
    logic [31:0]                tick_now    = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [OUT_W-1:0]    altitude_cm;
    logic                       calibrated;
    logic                       cfg_we      = 1'b0;
    logic [SETTLE_W-1:0]        cfg_wdata   = '0;

    // shadow state of the block
    logic [63:0]         gnd_est;
    logic [31:0]         still_since;
    longint              gnd_alt;
    logic                is_cal;
    logic [SETTLE_W-1:0] settle_cfg;

    t_result     pending_results[$];
    int          fail_count  = 0;
    int          words_sent  = 0;
    bit          steady_flow = 1'b0;   // no idling on either side while set
    logic [31:0] tick_clock;

    baro_ground_calibration_altitude_top #(
        .TICK_BITS          (32),
        .PRESSURE_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_pressure    (pressure),
        .i_tick_now    (tick_now),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_altitude_cm (altitude_cm),
        .o_calibrated  (calibrated),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // receiver stalls about 9 percent of the time unless the steady stretch is on
    always @(posedge clk) begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------

    function automatic longint clamp_out(input longint v);
        if (v > OUT_HI) return OUT_HI;
        if (v < OUT_LO) return OUT_LO;
        return v;
    endfunction

    // cubic law: 0.82 * (d/1000)^3 + 0.09 * d * 100, d = 101000 Pa - p, in cm
    function automatic longint altitude_of_q12(input logic [63:0] p12);
        logic [63:0] mag, t16, t2, t3, cub, lin, a;
        logic        below_ref;
        longint      r;
        below_ref = p12 > SEA_REF_Q12;
        mag = below_ref ? p12 - SEA_REF_Q12 : SEA_REF_Q12 - p12;
        if (mag > DELTA_CLAMP) mag = DELTA_CLAMP;
        t16 = (mag * 64'd16 + 64'd500) / 64'd1000;
        t2  = (t16 * t16 + 64'd32768) >> 16;
        t3  = (t2 * t16 + 64'd32768) >> 16;
        cub = (t3 * 64'd41 + 64'd25) / 64'd50;
        lin = mag * 64'd144;
        a   = (cub + lin + 64'd32768) >> 16;
        if (a > ALT_CLAMP) a = ALT_CLAMP;
        r = longint'(a);
        return below_ref ? -r : r;
    endfunction

    function automatic void clear_shadow();
        gnd_est     = EST_AT_RESET;
        still_since = '0;
        gnd_alt     = 0;
        is_cal      = 1'b0;
        settle_cfg  = SETTLE_RESET;
    endfunction

    // advance the shadow state by one accepted word and return its result
    function automatic t_result predict_word(input logic req,
                                             input logic [PRESS_W-1:0] press,
                                             input logic [31:0] tick);
        logic [63:0] p12, emag, nudge, est;
        logic        rising;
        logic [31:0] elapsed;
        longint      alt;
        t_result     r;
        p12 = 64'(press) << (Q12_SHIFT - FRAC_BITS);
        alt = 0;
        if (req == REQ_CALIB) begin
            still_since = tick;
            is_cal      = 1'b0;
        end else if (!is_cal) begin
            rising  = p12 >= gnd_est;
            emag    = rising ? p12 - gnd_est : gnd_est - p12;
            nudge   = (emag * EST_GAIN + 64'd32768) >> 16;
            est     = rising ? gnd_est + nudge : gnd_est - nudge;
            if (est > EST_CEIL) est = EST_CEIL;
            gnd_est = est;
            if (emag * TOL_RATIO < est) begin
                elapsed = tick - still_since;
                if (elapsed > 32'(settle_cfg)) begin
                    gnd_alt = clamp_out(altitude_of_q12(est));
                    is_cal  = 1'b1;
                end
            end else begin
                still_since = tick;
            end
        end else begin
            alt = clamp_out(altitude_of_q12(p12) - gnd_alt);
        end
        r.altitude_cm = alt[OUT_W-1:0];
        r.calibrated  = is_cal;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // one input word; returns once it is accepted and its result predicted
    task automatic send_word(input logic req, input logic [PRESS_W-1:0] press,
                             input logic [31:0] tick);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        pressure <= press;
        tick_now <= tick;
        do @(posedge clk); while (in_ready !== 1'b1);
        pending_results.push_back(predict_word(req, press, tick));
        words_sent++;
    endtask

    // hold the input off until every outstanding result has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // settle_ticks is only written with the block idle
    task automatic write_settle(input logic [SETTLE_W-1:0] v);
        wait_results_done();
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        settle_cfg = v;
    endtask

    function automatic logic [PRESS_W-1:0] jitter_press(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) v = 0;
        if (v > int'(PRESS_MAX)) v = int'(PRESS_MAX);
        return v[PRESS_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: altitude_cm %0d, calibrated %0b",
                       altitude_cm, calibrated);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (altitude_cm !== want.altitude_cm) begin
                    $error("altitude_cm mismatch: expected %0d, got %0d",
                           $signed(want.altitude_cm), altitude_cm);
                    fail_count++;
                end
                if (calibrated !== want.calibrated) begin
                    $error("calibrated mismatch: expected %0b, got %0b",
                           want.calibrated, calibrated);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // settle register at its reset value of 500, timer starts at 0
    task automatic test_reset_settle();
        send_word(REQ_SAMPLE, GROUND_Q4, 32'd500);   // exactly 500 ticks, still waiting
        send_word(REQ_SAMPLE, GROUND_Q4, 32'd501);   // completes calibration
    endtask

    // altitude words once calibrated, across the pressure range
    task automatic test_calibrated_extremes();
        send_word(REQ_SAMPLE, '0, 32'd502);
        send_word(REQ_SAMPLE, PRESS_MAX, 32'd503);
        send_word(REQ_SAMPLE, SEA_Q4, 32'd504);
        send_word(REQ_SAMPLE, GROUND_Q4, 32'd505);
        send_word(REQ_SAMPLE, 21'h155555, 32'd506);
        send_word(REQ_SAMPLE, 21'h0AAAAA, 32'd507);
    endtask

    // start request drops the flag; an out-of-tolerance sample restarts the timer
    task automatic test_start_request();
        send_word(REQ_CALIB, PRESS_MAX, 32'hFFFF_FFFF);
        send_word(REQ_SAMPLE, PRESS_W'(GROUND_Q4 + 6 * ONE_PA), 32'h0000_0400);
        // sender holds here until the block has answered everything
        wait_results_done();
    endtask

    // largest and smallest settle values, the largest across the tick wrap
    task automatic test_settle_extremes();
        write_settle(16'hFFFF);
        send_word(REQ_CALIB, '0, 32'hFFFF_FFF0);
        send_word(REQ_SAMPLE, GROUND_Q4, 32'h0000_FFEF);   // 65535 elapsed, not enough
        send_word(REQ_SAMPLE, GROUND_Q4, 32'h0000_FFF0);   // 65536 elapsed
        send_word(REQ_SAMPLE, PRESS_W'(GROUND_Q4 - 100 * ONE_PA), 32'h0001_0000);
        write_settle('0);
        send_word(REQ_CALIB, GROUND_Q4, 32'd1000);
        send_word(REQ_SAMPLE, GROUND_Q4, 32'd1000);        // zero elapsed is not past zero
        send_word(REQ_SAMPLE, GROUND_Q4, 32'd1001);
    endtask

    // one start request, noisy samples until calibrated, then altitude words
    task automatic run_calibration(input int unsigned tick_step_max);
        int          target, spread, tries, pick;
        int unsigned est_q4;
        est_q4 = int'(gnd_est >> (Q12_SHIFT - FRAC_BITS));
        if ($urandom_range(0, 4) == 0) begin
            target = int'($urandom_range(16000 * ONE_PA, int'(PRESS_MAX)));
        end else begin
            target = int'(jitter_press(int'(est_q4), 1000 * ONE_PA));
        end
        // noise stays inside the tolerance band of this ground pressure
        spread = int'($urandom_range(0, target / 40000));

        tick_clock += $urandom_range(1, tick_step_max);
        send_word(REQ_CALIB, PRESS_W'($urandom()), tick_clock);

        tries = 0;
        while (!is_cal && tries < 150) begin
            tick_clock += $urandom_range(1, tick_step_max);
            pick = int'($urandom_range(0, 99));
            if (pick < 1) begin
                // stray sample anywhere, knocks the estimate off
                send_word(REQ_SAMPLE, PRESS_W'($urandom()), tick_clock);
            end else if (pick < 3) begin
                send_word(REQ_SAMPLE, jitter_press(target, 50 * ONE_PA), tick_clock);
            end else if (pick < 5) begin
                // restart in the middle of settling
                send_word(REQ_CALIB, PRESS_W'($urandom()), tick_clock);
            end else begin
                send_word(REQ_SAMPLE, jitter_press(target, spread), tick_clock);
            end
            tries++;
        end

        repeat ($urandom_range(4, 16)) begin
            tick_clock += $urandom_range(1, tick_step_max);
            pick = int'($urandom_range(0, 9));
            if (pick < 5) begin
                send_word(REQ_SAMPLE, jitter_press(target, 2000 * ONE_PA), tick_clock);
            end else if (pick < 9) begin
                send_word(REQ_SAMPLE, PRESS_W'($urandom()), tick_clock);
            end else begin
                send_word(REQ_SAMPLE, $urandom_range(0, 1) ? PRESS_MAX : '0, tick_clock);
            end
        end
    endtask

    task automatic test_random_calibrations();
        int run_idx, stop_at;
        run_idx    = 0;
        stop_at    = words_sent + RANDOM_WORDS;
        tick_clock = $urandom();
        while (words_sent < stop_at) begin
            // new settle every few runs, extremes first
            if (run_idx % 4 == 0) begin
                case ((run_idx / 4) % 5)
                    0:       write_settle('0);
                    1:       write_settle(16'hFFFF);
                    2:       write_settle(16'd1);
                    3:       write_settle(SETTLE_W'($urandom_range(0, 65535)));
                    default: write_settle(SETTLE_W'($urandom_range(0, 300)));
                endcase
            end
            steady_flow = (run_idx >= 6 && run_idx < 10);
            if ($urandom_range(0, 7) == 0) wait_results_done();
            // ticks per sample scale so that a run settles in about a dozen samples
            run_calibration(int'(settle_cfg) / 8 + 2);
            run_idx++;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        clear_shadow();
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settle();
        test_calibrated_extremes();
        test_start_request();
        test_settle_extremes();
        test_random_calibrations();

        wait_results_done();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
